@@ hw/rtl/lever_pot_jog_slew_fsm_assert.svh @@
// ----------------------------------------------------------------------------
// Lever jog/slew controller assertion macros
// Concurrent assertion helpers used by the RTL file of the block.
// ----------------------------------------------------------------------------
`ifndef LEVER_POT_JOG_SLEW_FSM_ASSERT_SVH
`define LEVER_POT_JOG_SLEW_FSM_ASSERT_SVH

`ifndef SYNTH
`define LPJS_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpjs: same-cycle check failed");
`define LPJS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpjs: next-cycle check failed");
`else
`define LPJS_ASSERT_SAME(name, clk, rst, ante, cons)
`define LPJS_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

@@ hw/rtl/lpjs_pkg.sv @@
// ----------------------------------------------------------------------------
// Lever jog/slew controller package
// Types, register indexes, lever zone limits and scaling constants.
// ----------------------------------------------------------------------------
`default_nettype none

package lpjs_pkg;

   localparam int ADC_W      = 10;
   localparam int SPEED_W    = 16;
   localparam int CSR_W      = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int DIST_W     = 9;
   localparam int PCT_W      = 7;
   localparam int PROD_W     = SPEED_W + PCT_W;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_TURNL = 3'd1,
      MODE_SLEWL = 3'd2,
      MODE_TURNR = 3'd3,
      MODE_SLEWR = 3'd4,
      MODE_STOP  = 3'd5,
      MODE_INIT  = 3'd6
   } mode_type;

   typedef enum logic [1:0] {
      CMD_NONE      = 2'd0,
      CMD_JOG_TURN  = 2'd1,
      CMD_JOG_SPEED = 2'd2,
      CMD_STOP      = 2'd3
   } cmd_type;

   localparam logic DIR_LEFT  = 1'b0;
   localparam logic DIR_RIGHT = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_SLEW_RATE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLDOFF_TICKS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STARTUP_TICKS = 2'd2;

   localparam logic [CSR_W-1:0] SLEW_RATE_RST     = 16'd1000;
   localparam logic [CSR_W-1:0] HOLDOFF_TICKS_RST = 16'd50;
   localparam logic [CSR_W-1:0] STARTUP_TICKS_RST = 16'd1000;

   localparam logic [ADC_W-1:0] ADC_OPEN_MAX   = 10'd7;
   localparam logic [ADC_W-1:0] ADC_SLEWL_EDGE = 10'd356;
   localparam logic [ADC_W-1:0] ADC_TURNL_LO   = 10'd367;
   localparam logic [ADC_W-1:0] ADC_TURNL_HI   = 10'd456;
   localparam logic [ADC_W-1:0] ADC_CENTER_HI  = 10'd567;
   localparam logic [ADC_W-1:0] ADC_TURNR_LO   = 10'd568;
   localparam logic [ADC_W-1:0] ADC_TURNR_END  = 10'd657;
   localparam logic [ADC_W-1:0] ADC_SLEWR_EDGE = 10'd667;

   // Percent of full deflection is dist * 100 / 356, done as a multiply by
   // round-up(2^20 * 25 / 89) and a shift; exact for every 9-bit distance.
   localparam int PCT_SHIFT = 20;
   localparam int PCT_PROD_W = DIST_W + 19;
   localparam logic [PCT_PROD_W-1:0] PCT_MULT = 28'd294544;

   // Division by 100 as a multiply by round-up(2^30 / 100) and a shift;
   // exact for every product of a 16-bit rate and a percent up to 100.
   localparam int HUND_SHIFT = 30;
   localparam int HUND_PROD_W = PROD_W + 24;
   localparam logic [HUND_PROD_W-1:0] HUND_MULT = 47'd10737419;

endpackage

`default_nettype wire

@@ hw/rtl/lpjs_if.sv @@
// ----------------------------------------------------------------------------
// Lever jog/slew controller channels
// Valid/ready interfaces for the sample channel and the command channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpjs_req_if;
   import lpjs_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [ADC_W-1:0]     adc_value;
   logic                 tick;
   logic [SPEED_W-1:0]   jog_speed;

   modport source (output valid, output adc_value, output tick, output jog_speed,
                   input ready);
   modport sink (input valid, input adc_value, input tick, input jog_speed,
                 output ready);
endinterface

interface lpjs_rsp_if;
   import lpjs_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [1:0]           command;
   logic                 direction;
   logic [SPEED_W-1:0]   speed;
   logic [2:0]           mode;

   modport source (output valid, output command, output direction, output speed,
                   output mode, input ready);
   modport sink (input valid, input command, input direction, input speed,
                 input mode, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lever_pot_jog_slew_fsm.sv @@
// ----------------------------------------------------------------------------
// Lever potentiometer jog/slew controller
// Turns polled lever samples into motor jog, slew and stop commands.
// ----------------------------------------------------------------------------
// Samples arrive on req_ch, one transaction per sample with its tick flag
// and the turn jog speed the driver reports. Each sample yields exactly one
// command transaction on rsp_ch, in order.
// The mode machine and holdoff counter update in the cycle a sample is
// taken. The slew speed then passes a multiply stage and a scaling stage,
// so a command passes stage a, stage b and the output register in turn;
// one sample per cycle is sustained while rsp_ch takes each command, set
// by the three-stage valid/ready pipeline.
// When rsp_ch stalls, the command is held in the output register and the
// stages behind it fill up; req_ch.ready drops only when all are full.
// The csr port writes slew_rate, holdoff_ticks and startup_ticks; write it
// only while no transaction is in flight.
// Reset (synchronous, active high) restores the register defaults, puts
// the machine in its init mode with the holdoff loaded from startup_ticks,
// and empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module lever_pot_jog_slew_fsm (
   input  wire logic                              clock,
   input  wire logic                              reset,
   lpjs_req_if.sink                               req_ch,
   lpjs_rsp_if.source                             rsp_ch,
   input  wire logic                              csr_we,
   input  wire logic [lpjs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [lpjs_pkg::CSR_W-1:0]        csr_wdata
);
   import lpjs_pkg::*;

   typedef struct packed {
      cmd_type             cmd;
      logic                dir;
      mode_type            mode;
      logic [PCT_W-1:0]    pct;
      logic [SPEED_W-1:0]  floor;
   } stage_a_type;

   typedef struct packed {
      cmd_type             cmd;
      logic                dir;
      mode_type            mode;
      logic [PROD_W-1:0]   prod;
      logic [SPEED_W-1:0]  floor;
   } stage_b_type;

   logic [CSR_W-1:0]    slew_rate_ff, slew_rate_in;
   logic [CSR_W-1:0]    holdoff_ticks_ff, holdoff_ticks_in;
   logic [CSR_W-1:0]    startup_ticks_ff, startup_ticks_in;

   mode_type            mode_ff, mode_in;
   logic [ADC_W-1:0]    last_sample_ff, last_sample_in;
   logic [CSR_W-1:0]    holdoff_count_ff, holdoff_count_in;
   logic [SPEED_W-1:0]  floor_speed_ff, floor_speed_in;

   logic                a_valid_ff, a_valid_in;
   stage_a_type         a_ff, a_in;
   logic                b_valid_ff, b_valid_in;
   stage_b_type         b_ff, b_in;
   logic                rsp_valid_ff, rsp_valid_in;
   cmd_type             rsp_cmd_ff, rsp_cmd_in;
   logic                rsp_dir_ff, rsp_dir_in;
   mode_type            rsp_mode_ff, rsp_mode_in;
   logic [SPEED_W-1:0]  rsp_speed_ff, rsp_speed_in;

   logic                rsp_free, b_free, a_free;
   logic                req_fire;
   logic [CSR_W-1:0]    count_dec;
   logic                eval;
   cmd_type             cmd;
   logic                dir;
   logic [DIST_W-1:0]   lever_dist;
   logic [PCT_PROD_W-1:0]  pct_prod;
   logic [HUND_PROD_W-1:0] hund_prod;
   logic [SPEED_W-1:0]  scaled;
   logic [ADC_W-1:0]    adc;

   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign b_free   = !b_valid_ff || rsp_free;
   assign a_free   = !a_valid_ff || b_free;
   assign req_fire = req_ch.valid && a_free;
   assign adc      = req_ch.adc_value;

   assign req_ch.ready     = a_free;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.command   = rsp_cmd_ff;
   assign rsp_ch.direction = rsp_dir_ff;
   assign rsp_ch.speed     = rsp_speed_ff;
   assign rsp_ch.mode      = rsp_mode_ff;

   assign count_dec = (req_ch.tick && holdoff_count_ff != '0) ?
                      holdoff_count_ff - CSR_W'(1) : holdoff_count_ff;
   assign eval = (adc != last_sample_ff) && (count_dec == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_INIT;
      end else begin
         mode_ff <= mode_in;
      end
   end

   always_comb begin
      mode_in        = mode_ff;
      floor_speed_in = floor_speed_ff;
      cmd            = CMD_NONE;
      dir            = DIR_LEFT;
      lever_dist     = '0;
      if (req_fire && eval) begin
         unique case (mode_ff)
            MODE_IDLE: begin
               if (adc < ADC_SLEWL_EDGE && adc > ADC_OPEN_MAX) begin
                  mode_in = MODE_SLEWL;
               end else if (adc >= ADC_TURNL_LO && adc <= ADC_TURNL_HI) begin
                  cmd            = CMD_JOG_TURN;
                  dir            = DIR_LEFT;
                  floor_speed_in = req_ch.jog_speed;
                  mode_in        = MODE_TURNL;
               end else if (adc >= ADC_TURNR_LO && adc < ADC_TURNR_END) begin
                  cmd            = CMD_JOG_TURN;
                  dir            = DIR_RIGHT;
                  floor_speed_in = req_ch.jog_speed;
                  mode_in        = MODE_TURNR;
               end else if (adc >= ADC_SLEWR_EDGE) begin
                  mode_in = MODE_SLEWR;
               end
            end
            MODE_TURNL: begin
               if (adc >= ADC_TURNL_LO && adc <= ADC_TURNL_HI) begin
                  cmd            = CMD_JOG_TURN;
                  dir            = DIR_LEFT;
                  floor_speed_in = req_ch.jog_speed;
               end else if (adc < ADC_SLEWL_EDGE) begin
                  mode_in = MODE_SLEWL;
               end else if (adc > ADC_TURNL_HI) begin
                  mode_in = MODE_STOP;
               end
            end
            MODE_SLEWL: begin
               if (adc >= ADC_SLEWL_EDGE) begin
                  mode_in = MODE_STOP;
               end else begin
                  cmd        = CMD_JOG_SPEED;
                  dir        = DIR_LEFT;
                  lever_dist = DIST_W'(ADC_SLEWL_EDGE - adc);
               end
            end
            MODE_TURNR: begin
               if (adc >= ADC_TURNR_LO && adc < ADC_TURNR_END) begin
                  cmd = CMD_JOG_TURN;
                  dir = DIR_RIGHT;
               end else if (adc >= ADC_SLEWR_EDGE) begin
                  mode_in = MODE_SLEWR;
               end else if (adc < ADC_CENTER_HI) begin
                  mode_in = MODE_STOP;
               end
            end
            MODE_SLEWR: begin
               if (adc < ADC_SLEWR_EDGE) begin
                  mode_in = MODE_STOP;
               end else begin
                  cmd        = CMD_JOG_SPEED;
                  dir        = DIR_RIGHT;
                  lever_dist = DIST_W'(adc - ADC_SLEWR_EDGE);
               end
            end
            MODE_STOP: begin
               if (adc > ADC_TURNL_HI && adc <= ADC_CENTER_HI) begin
                  mode_in = MODE_IDLE;
               end
               cmd = CMD_STOP;
            end
            default: begin
               if (adc > ADC_TURNL_HI && adc < ADC_CENTER_HI) begin
                  floor_speed_in = '0;
                  mode_in        = MODE_IDLE;
               end
            end
         endcase
      end
   end

   assign pct_prod  = PCT_PROD_W'(lever_dist) * PCT_MULT;
   assign hund_prod = HUND_PROD_W'(b_ff.prod) * HUND_MULT;
   assign scaled    = hund_prod[HUND_SHIFT +: SPEED_W];

   always_comb begin
      slew_rate_in     = slew_rate_ff;
      holdoff_ticks_in = holdoff_ticks_ff;
      startup_ticks_in = startup_ticks_ff;
      last_sample_in   = last_sample_ff;
      holdoff_count_in = holdoff_count_ff;
      if (req_fire) begin
         if (eval) begin
            holdoff_count_in = holdoff_ticks_ff;
            last_sample_in   = adc;
         end else begin
            holdoff_count_in = count_dec;
         end
      end
      if (csr_we) begin
         unique case (csr_index)
            CSR_SLEW_RATE:     slew_rate_in = csr_wdata;
            CSR_HOLDOFF_TICKS: holdoff_ticks_in = csr_wdata;
            CSR_STARTUP_TICKS: begin
               startup_ticks_in = csr_wdata;
               if (mode_ff == MODE_INIT) begin
                  holdoff_count_in = csr_wdata;
               end
            end
            default: ;
         endcase
      end

      a_valid_in = a_valid_ff;
      a_in       = a_ff;
      if (a_free) begin
         a_valid_in = req_fire;
         a_in.cmd   = cmd;
         a_in.dir   = dir;
         a_in.mode  = mode_in;
         a_in.pct   = pct_prod[PCT_SHIFT +: PCT_W];
         a_in.floor = floor_speed_ff;
      end

      b_valid_in = b_valid_ff;
      b_in       = b_ff;
      if (b_free) begin
         b_valid_in = a_valid_ff;
         b_in.cmd   = a_ff.cmd;
         b_in.dir   = a_ff.dir;
         b_in.mode  = a_ff.mode;
         b_in.prod  = PROD_W'(slew_rate_ff * a_ff.pct);
         b_in.floor = a_ff.floor;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_cmd_in   = rsp_cmd_ff;
      rsp_dir_in   = rsp_dir_ff;
      rsp_mode_in  = rsp_mode_ff;
      rsp_speed_in = rsp_speed_ff;
      if (rsp_free) begin
         rsp_valid_in = b_valid_ff;
         rsp_cmd_in   = b_ff.cmd;
         rsp_dir_in   = b_ff.dir;
         rsp_mode_in  = b_ff.mode;
         if (b_ff.cmd != CMD_JOG_SPEED) begin
            rsp_speed_in = '0;
         end else if (scaled < b_ff.floor) begin
            rsp_speed_in = b_ff.floor;
         end else begin
            rsp_speed_in = scaled;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slew_rate_ff     <= SLEW_RATE_RST;
         holdoff_ticks_ff <= HOLDOFF_TICKS_RST;
         startup_ticks_ff <= STARTUP_TICKS_RST;
         last_sample_ff   <= '0;
         holdoff_count_ff <= STARTUP_TICKS_RST;
         floor_speed_ff   <= '0;
         a_valid_ff       <= 1'b0;
         b_valid_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         slew_rate_ff     <= slew_rate_in;
         holdoff_ticks_ff <= holdoff_ticks_in;
         startup_ticks_ff <= startup_ticks_in;
         last_sample_ff   <= last_sample_in;
         holdoff_count_ff <= holdoff_count_in;
         floor_speed_ff   <= floor_speed_in;
         a_valid_ff       <= a_valid_in;
         b_valid_ff       <= b_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff         <= a_in;
      b_ff         <= b_in;
      rsp_cmd_ff   <= rsp_cmd_in;
      rsp_dir_ff   <= rsp_dir_in;
      rsp_mode_ff  <= rsp_mode_in;
      rsp_speed_ff <= rsp_speed_in;
   end

`include "lever_pot_jog_slew_fsm_assert.svh"

   `LPJS_ASSERT_SAME(a_speed_only_on_slew, clock, reset,
      rsp_valid_ff && rsp_cmd_ff != CMD_JOG_SPEED, rsp_speed_ff == '0)
   `LPJS_ASSERT_SAME(a_stop_cmd_mode, clock, reset,
      a_valid_ff && a_ff.cmd == CMD_STOP,
      a_ff.mode == MODE_STOP || a_ff.mode == MODE_IDLE)
   `LPJS_ASSERT_NEXT(a_holdoff_reload, clock, reset,
      req_fire && eval && !csr_we, holdoff_count_ff == $past(holdoff_ticks_ff))
   `LPJS_ASSERT_NEXT(a_mode_held_without_eval, clock, reset,
      !(req_fire && eval), mode_ff == $past(mode_ff))

endmodule

`default_nettype wire

@@ test/lever_cmd_checker.sv @@
// ----------------------------------------------------------------------------
// Lever jog/slew controller checker
// Watches the sample, command and register ports. It keeps its own model of
// the mode machine, the holdoff counter and the remembered turn speed. For
// each accepted sample transaction it queues the expected command, and it
// compares each accepted command transaction field by field with the oldest
// one in the queue.
// ----------------------------------------------------------------------------
module lever_cmd_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   lpjs_req_if                                   req,
   lpjs_rsp_if                                   rsp,
   input  wire logic                             csr_we,
   input  wire logic [lpjs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [lpjs_pkg::CSR_W-1:0]       csr_wdata,
   output int                                    fail_count,
   output int                                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import lpjs_pkg::*;

   localparam int unsigned LEVER_SPAN = ADC_SLEWL_EDGE;
   localparam int unsigned PERCENT    = 100;

   typedef struct packed {
      cmd_type              command;
      logic                 direction;
      logic [SPEED_W-1:0]   speed;
      mode_type             mode;
   } lever_cmd_type;

   logic [CSR_W-1:0]   slew_rate_q;
   logic [CSR_W-1:0]   holdoff_reload_q;
   logic [CSR_W-1:0]   startup_q;
   logic [CSR_W-1:0]   holdoff_q;
   logic [SPEED_W-1:0] floor_speed_q;
   logic [ADC_W-1:0]   last_sample_q;
   mode_type           mode_q;
   lever_cmd_type      expected_cmds[$];

   function automatic logic [SPEED_W-1:0] slew_speed(input int unsigned lever_dist);
      int unsigned pct;
      int unsigned spd;
      pct = (lever_dist * PERCENT) / LEVER_SPAN;
      spd = (int'(slew_rate_q) * pct) / PERCENT;
      if (spd < floor_speed_q) begin
         spd = floor_speed_q;
      end
      return spd[SPEED_W-1:0];
   endfunction

   function automatic lever_cmd_type lever_step(input logic [ADC_W-1:0] a, input logic tk,
                                                input logic [SPEED_W-1:0] js);
      lever_cmd_type r;
      r.command   = CMD_NONE;
      r.direction = DIR_LEFT;
      r.speed     = '0;
      if (tk && holdoff_q != 0) begin
         holdoff_q = holdoff_q - 1'b1;
      end
      if (a != last_sample_q && holdoff_q == 0) begin
         holdoff_q     = holdoff_reload_q;
         last_sample_q = a;
         case (mode_q)
            MODE_IDLE: begin
               if (a < ADC_SLEWL_EDGE && a > ADC_OPEN_MAX) begin
                  mode_q = MODE_SLEWL;
               end else if (a >= ADC_TURNL_LO && a <= ADC_TURNL_HI) begin
                  r.command     = CMD_JOG_TURN;
                  r.direction   = DIR_LEFT;
                  floor_speed_q = js;
                  mode_q        = MODE_TURNL;
               end else if (a >= ADC_TURNR_LO && a < ADC_TURNR_END) begin
                  r.command     = CMD_JOG_TURN;
                  r.direction   = DIR_RIGHT;
                  floor_speed_q = js;
                  mode_q        = MODE_TURNR;
               end else if (a >= ADC_SLEWR_EDGE) begin
                  mode_q = MODE_SLEWR;
               end
            end
            MODE_TURNL: begin
               if (a >= ADC_TURNL_LO && a <= ADC_TURNL_HI) begin
                  r.command     = CMD_JOG_TURN;
                  r.direction   = DIR_LEFT;
                  floor_speed_q = js;
               end else if (a < ADC_SLEWL_EDGE) begin
                  mode_q = MODE_SLEWL;
               end else if (a > ADC_TURNL_HI) begin
                  mode_q = MODE_STOP;
               end
            end
            MODE_SLEWL: begin
               if (a >= ADC_SLEWL_EDGE) begin
                  mode_q = MODE_STOP;
               end else begin
                  r.command   = CMD_JOG_SPEED;
                  r.direction = DIR_LEFT;
                  r.speed     = slew_speed(int'(ADC_SLEWL_EDGE) - int'(a));
               end
            end
            MODE_TURNR: begin
               if (a >= ADC_TURNR_LO && a < ADC_TURNR_END) begin
                  r.command   = CMD_JOG_TURN;
                  r.direction = DIR_RIGHT;
               end else if (a >= ADC_SLEWR_EDGE) begin
                  mode_q = MODE_SLEWR;
               end else if (a < ADC_CENTER_HI) begin
                  mode_q = MODE_STOP;
               end
            end
            MODE_SLEWR: begin
               if (a < ADC_SLEWR_EDGE) begin
                  mode_q = MODE_STOP;
               end else begin
                  r.command   = CMD_JOG_SPEED;
                  r.direction = DIR_RIGHT;
                  r.speed     = slew_speed(int'(a) - int'(ADC_SLEWR_EDGE));
               end
            end
            MODE_STOP: begin
               if (a > ADC_TURNL_HI && a <= ADC_CENTER_HI) begin
                  mode_q = MODE_IDLE;
               end
               r.command = CMD_STOP;
            end
            default: begin
               if (a > ADC_TURNL_HI && a < ADC_CENTER_HI) begin
                  floor_speed_q = '0;
                  mode_q        = MODE_IDLE;
               end
            end
         endcase
      end
      r.mode = mode_q;
      return r;
   endfunction

   always @(posedge clock) begin
      lever_cmd_type want;
      if (reset) begin
         slew_rate_q      = SLEW_RATE_RST;
         holdoff_reload_q = HOLDOFF_TICKS_RST;
         startup_q        = STARTUP_TICKS_RST;
         holdoff_q        = STARTUP_TICKS_RST;
         floor_speed_q    = '0;
         last_sample_q    = '0;
         mode_q           = MODE_INIT;
         fail_count       = 0;
         expected_cmds.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SLEW_RATE:     slew_rate_q = csr_wdata;
               CSR_HOLDOFF_TICKS: holdoff_reload_q = csr_wdata;
               CSR_STARTUP_TICKS: begin
                  startup_q = csr_wdata;
                  if (mode_q == MODE_INIT) begin
                     holdoff_q = csr_wdata;
                  end
               end
               default: ;
            endcase
         end
         if (req.valid && req.ready) begin
            expected_cmds.push_back(lever_step(req.adc_value, req.tick, req.jog_speed));
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_cmds.size() == 0) begin
               $error("command transaction with no sample waiting: command %0d, mode %0d",
                      rsp.command, rsp.mode);
               fail_count++;
            end else begin
               want = expected_cmds.pop_front();
               if (rsp.command !== want.command) begin
                  $error("command: expected %0d, got %0d", want.command, rsp.command);
                  fail_count++;
               end
               if (rsp.direction !== want.direction) begin
                  $error("direction: expected %0d, got %0d", want.direction, rsp.direction);
                  fail_count++;
               end
               if (rsp.speed !== want.speed) begin
                  $error("speed: expected %0d, got %0d", want.speed, rsp.speed);
                  fail_count++;
               end
               if (rsp.mode !== want.mode) begin
                  $error("mode: expected %0d, got %0d", want.mode, rsp.mode);
                  fail_count++;
               end
            end
         end
      end
      pending <= expected_cmds.size();
   end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Lever jog/slew controller testbench
// Drives lever samples through the controller: a directed walk through every
// mode and zone edge, then random lever gestures under several register
// settings, with random gaps and stalls on both channels and one long stall
// of the command channel. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lpjs_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int DUT_LATENCY  = 3;
   localparam int HOLD_CYCLES  = 60;
   localparam int PHASE_ITEMS  = 280;
   localparam int PHASES       = 6;
   localparam int TIMEOUT_NS   = 4_000_000;

   localparam logic [ADC_W-1:0] DIRECTED_PATH [27] = '{
      0, 1023, 456, 567, 457, 7, 366, 8, 0, 355, 356, 1023, 567, 456,
      367, 360, 457, 500, 656, 568, 567, 667, 1023, 668, 666, 458, 1023
   };

   typedef enum int {
      Z_OPEN, Z_SLEWL, Z_GAPL, Z_TURNL, Z_CENTER, Z_TURNR, Z_GAPR, Z_SLEWR
   } zone_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_W-1:0]       csr_wdata;
   int                     fail_count;
   int                     pending;
   int                     sent_count = 0;
   bit                     idle_on = 1'b1;
   bit                     hold_rsp = 1'b0;

   lpjs_req_if req_ch ();
   lpjs_rsp_if rsp_ch ();

   lever_pot_jog_slew_fsm i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lever_cmd_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #6 clock = ~clock;

   initial begin
      #(TIMEOUT_NS);
      $display("CHECK FAILED");
      $finish;
   end

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_sample(input logic [ADC_W-1:0] adc, input logic tk,
                              input logic [SPEED_W-1:0] js);
      int gap;
      gap = idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.adc_value <= adc;
      req_ch.tick      <= tk;
      req_ch.jog_speed <= js;
      do @(posedge clock); while (!req_ch.ready);
      sent_count++;
   endtask

   // Waits until every queued command has come back and the pipeline is empty.
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DUT_LATENCY + 1) @(posedge clock);
   endtask

   function automatic logic [SPEED_W-1:0] jog_value();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) begin
         return '0;
      end else if (pick == 1) begin
         return '1;
      end
      return SPEED_W'($urandom);
   endfunction

   function automatic logic [ADC_W-1:0] zone_value(input zone_type z);
      int lo;
      int hi;
      int pick;
      case (z)
         Z_OPEN:   begin lo = 0;                  hi = ADC_OPEN_MAX;       end
         Z_SLEWL:  begin lo = ADC_OPEN_MAX + 1;   hi = ADC_SLEWL_EDGE - 1; end
         Z_GAPL:   begin lo = ADC_SLEWL_EDGE;     hi = ADC_TURNL_LO - 1;   end
         Z_TURNL:  begin lo = ADC_TURNL_LO;       hi = ADC_TURNL_HI;       end
         Z_CENTER: begin lo = ADC_TURNL_HI + 1;   hi = ADC_CENTER_HI;      end
         Z_TURNR:  begin lo = ADC_TURNR_LO;       hi = ADC_TURNR_END - 1;  end
         Z_GAPR:   begin lo = ADC_TURNR_END;      hi = ADC_SLEWR_EDGE - 1; end
         default:  begin lo = ADC_SLEWR_EDGE;     hi = (1 << ADC_W) - 1;   end
      endcase
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         return ADC_W'(lo);
      end else if (pick == 1) begin
         return ADC_W'(hi);
      end
      return ADC_W'($urandom_range(lo, hi));
   endfunction

   // Mostly a full lever movement out of the center and back, sometimes a stray zone.
   task automatic lever_gesture();
      zone_type zones[$];
      bit       right;
      if ($urandom_range(0, 3) == 0) begin
         zones.push_back(zone_type'($urandom_range(0, 7)));
      end else begin
         right = $urandom_range(0, 1);
         zones.push_back(Z_CENTER);
         zones.push_back(right ? Z_TURNR : Z_TURNL);
         repeat ($urandom_range(0, 4)) zones.push_back(right ? Z_SLEWR : Z_SLEWL);
         if ($urandom_range(0, 1) == 1) begin
            zones.push_back(right ? Z_TURNR : Z_TURNL);
         end
         zones.push_back(Z_CENTER);
      end
      idle_on = ($urandom_range(0, 3) != 0);
      foreach (zones[k]) begin
         repeat ($urandom_range(1, 3)) begin
            send_sample(zone_value(zones[k]), ($urandom_range(0, 3) != 0), jog_value());
         end
      end
   endtask

   initial begin : rsp_sink
      int n_wait;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
            n_wait = 0;
         end else begin
            n_wait = idle_on ? $urandom_range(0, 6) : 0;
         end
         if (n_wait > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (n_wait) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   initial begin : stimulus
      int target;
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= '0;
      csr_wdata        <= '0;
      req_ch.valid     <= 1'b0;
      req_ch.adc_value <= '0;
      req_ch.tick      <= 1'b0;
      req_ch.jog_speed <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The startup holdoff blocks evaluation until it is rewritten while still in init.
      csr_write(CSR_STARTUP_TICKS, '1);
      send_sample(10'd500, 1'b1, '0);
      send_sample(10'd500, 1'b0, '1);
      settle();
      csr_write(CSR_HOLDOFF_TICKS, '0);
      csr_write(CSR_STARTUP_TICKS, '0);
      csr_write(CSR_UNUSED, '1);
      foreach (DIRECTED_PATH[k]) begin
         send_sample(DIRECTED_PATH[k], 1'b1, jog_value());
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         case (ph)
            0: begin
               csr_write(CSR_SLEW_RATE, '1);
               csr_write(CSR_HOLDOFF_TICKS, '0);
            end
            1: begin
               csr_write(CSR_SLEW_RATE, '0);
               csr_write(CSR_HOLDOFF_TICKS, 16'd1);
            end
            2: begin
               csr_write(CSR_SLEW_RATE, CSR_W'($urandom));
               csr_write(CSR_HOLDOFF_TICKS, 16'd2);
            end
            3: begin
               csr_write(CSR_SLEW_RATE, SLEW_RATE_RST);
               csr_write(CSR_HOLDOFF_TICKS, CSR_W'($urandom_range(0, 5)));
            end
            4: begin
               csr_write(CSR_SLEW_RATE, CSR_W'($urandom));
               csr_write(CSR_HOLDOFF_TICKS, '0);
            end
            default: begin
               csr_write(CSR_SLEW_RATE, '1);
               csr_write(CSR_HOLDOFF_TICKS, 16'd3);
            end
         endcase
         csr_write(CSR_STARTUP_TICKS, CSR_W'($urandom));
         if (ph == 2) begin
            hold_rsp = 1'b1;
         end
         target = sent_count + PHASE_ITEMS;
         while (sent_count < target) lever_gesture();
      end

      // With the longest holdoff only the first change is evaluated.
      settle();
      csr_write(CSR_HOLDOFF_TICKS, '1);
      csr_write(CSR_SLEW_RATE, CSR_W'($urandom));
      repeat (20) send_sample(zone_value(zone_type'($urandom_range(0, 7))), 1'b1, jog_value());
      settle();

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
